// ----- rtl/spsp_pkg.sv -----
// shared types, widths and codes for the segment / plane split point block
// no dependencies
`default_nettype none

package spsp_pkg;

   localparam int CoordW        = 32;
   localparam int ProdW         = 2 * CoordW;
   localparam int EW            = ProdW + 2;
   localparam int MagW          = EW + 1;
   localparam int QW            = 16;
   localparam int DiffW         = CoordW + 1;
   localparam int ScaleW        = DiffW + QW + 1;
   localparam int StepsPerStage = 2;

   localparam int CsrIdxW       = 2;
   localparam int CsrDataW      = CoordW;
   localparam int NumRegs       = 4;
   localparam int ReqDataW      = 6 * CoordW;
   localparam int RspDataW      = 104;
   localparam int RspPadW       = RspDataW - 4 - 3 * CoordW;

   localparam logic [CsrIdxW-1:0] RegPlaneA      = 2'd0;
   localparam logic [CsrIdxW-1:0] RegPlaneB      = 2'd1;
   localparam logic [CsrIdxW-1:0] RegPlaneC      = 2'd2;
   localparam logic [CsrIdxW-1:0] RegPlaneOffset = 2'd3;

   localparam logic [1:0] SideBelow = 2'd0;
   localparam logic [1:0] SideOn    = 2'd1;
   localparam logic [1:0] SideAbove = 2'd2;

   typedef logic [2:0][CoordW-1:0] coord3_type;

   typedef struct packed {
      logic [1:0] start_side;
      logic [1:0] end_side;
      logic       crosses;
   } side_info_type;

   typedef struct packed {
      coord3_type    p0;
      coord3_type    p1;
      side_info_type info;
   } seg_type;

   typedef struct packed {
      seg_type         seg;
      logic [MagW-1:0] rem;
      logic [MagW-1:0] den;
      logic [QW-1:0]   quo;
   } div_type;

   typedef struct packed {
      side_info_type info;
      coord3_type    split;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/spsp_plane_eval.sv -----
// plane value of both endpoints, side codes, magnitudes and ratio denominator
// five register stages; uses spsp_pkg
`default_nettype none

module spsp_plane_eval import spsp_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire coord3_type                     in_p0,
   input  wire coord3_type                     in_p1,
   input  wire logic [NumRegs-1:0][CoordW-1:0] plane,
   output logic                                out_valid,
   output div_type                             out_data
);

   logic [4:0] valid_ff;

   // stage 1: products
   logic signed [ProdW-1:0] mul0_in [3];
   logic signed [ProdW-1:0] mul1_in [3];
   logic signed [ProdW-1:0] mul0_ff [3];
   logic signed [ProdW-1:0] mul1_ff [3];
   seg_type                 s1_seg_ff;

   // stage 2: pair sums
   logic [ProdW-1:0]        doff;
   logic [ProdW:0]          sa0_ff, sb0_ff, sa1_ff, sb1_ff;
   seg_type                 s2_seg_ff;

   // stage 3: plane values
   logic [EW-1:0]           e0_ff, e1_ff;
   seg_type                 s3_seg_ff;

   // stage 4: sides and magnitudes
   logic [1:0]              side0, side1;
   logic [EW-1:0]           m0_ff, m1_ff;
   seg_type                 s4_seg_ff;

   // stage 5: denominator
   div_type                 s5_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mul0_in[k] = $signed(plane[k]) * $signed(in_p0[k]);
         mul1_in[k] = $signed(plane[k]) * $signed(in_p1[k]);
      end
   end

   assign doff = {{(ProdW-CoordW-16){plane[RegPlaneOffset][CoordW-1]}},
                  plane[RegPlaneOffset], 16'b0};

   always_comb begin
      if (e0_ff[EW-1]) begin
         side0 = SideBelow;
      end else if (e0_ff == '0) begin
         side0 = SideOn;
      end else begin
         side0 = SideAbove;
      end
      if (e1_ff[EW-1]) begin
         side1 = SideBelow;
      end else if (e1_ff == '0) begin
         side1 = SideOn;
      end else begin
         side1 = SideAbove;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mul0_ff[k] <= mul0_in[k];
            mul1_ff[k] <= mul1_in[k];
         end
         s1_seg_ff.p0   <= in_p0;
         s1_seg_ff.p1   <= in_p1;
         s1_seg_ff.info <= '0;

         sa0_ff <= {mul0_ff[0][ProdW-1], mul0_ff[0]} + {mul0_ff[1][ProdW-1], mul0_ff[1]};
         sb0_ff <= {mul0_ff[2][ProdW-1], mul0_ff[2]} - {doff[ProdW-1], doff};
         sa1_ff <= {mul1_ff[0][ProdW-1], mul1_ff[0]} + {mul1_ff[1][ProdW-1], mul1_ff[1]};
         sb1_ff <= {mul1_ff[2][ProdW-1], mul1_ff[2]} - {doff[ProdW-1], doff};
         s2_seg_ff <= s1_seg_ff;

         e0_ff <= {sa0_ff[ProdW], sa0_ff} + {sb0_ff[ProdW], sb0_ff};
         e1_ff <= {sa1_ff[ProdW], sa1_ff} + {sb1_ff[ProdW], sb1_ff};
         s3_seg_ff <= s2_seg_ff;

         m0_ff <= e0_ff[EW-1] ? (~e0_ff + 1'b1) : e0_ff;
         m1_ff <= e1_ff[EW-1] ? (~e1_ff + 1'b1) : e1_ff;
         s4_seg_ff.p0              <= s3_seg_ff.p0;
         s4_seg_ff.p1              <= s3_seg_ff.p1;
         s4_seg_ff.info.start_side <= side0;
         s4_seg_ff.info.end_side   <= side1;
         s4_seg_ff.info.crosses    <= (side0 != SideOn) && (side1 != SideOn) &&
                                      (side0 != side1);

         s5_ff.seg <= s4_seg_ff;
         s5_ff.rem <= {1'b0, m0_ff};
         s5_ff.den <= {1'b0, m0_ff} + {1'b0, m1_ff};
         s5_ff.quo <= '0;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = s5_ff;

endmodule

`default_nettype wire

// ----- rtl/spsp_div_stage.sv -----
// one register stage of the restoring divider for the Q0.16 ratio
// retires Steps quotient bits per stage; uses spsp_pkg
`default_nettype none

module spsp_div_stage import spsp_pkg::*; #(
   parameter int unsigned Steps = StepsPerStage
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output div_type      out_data
);

   div_type      work_in;
   logic [MagW:0] shifted;
   logic          ge;
   logic          valid_ff;
   div_type       data_ff;

   always_comb begin
      work_in = in_data;
      shifted = '0;
      ge      = 1'b0;
      for (int i = 0; i < Steps; i++) begin
         shifted     = {work_in.rem, 1'b0};
         ge          = shifted >= {1'b0, work_in.den};
         work_in.rem = ge ? MagW'(shifted - {1'b0, work_in.den}) : shifted[MagW-1:0];
         work_in.quo = {work_in.quo[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/spsp_interp.sv -----
// split point p0 + floor((p1 - p0) * r / 65536), zeroed when not crossing
// three register stages; uses spsp_pkg
`default_nettype none

module spsp_interp import spsp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output result_type   out_data
);

   logic [2:0]               valid_ff;

   logic [DiffW-1:0]         diff_ff [3];
   coord3_type               a_p0_ff;
   side_info_type            a_info_ff;
   logic [QW-1:0]            a_quo_ff;

   logic signed [ScaleW-1:0] scale_in [3];
   logic signed [ScaleW-1:0] scale_ff [3];
   coord3_type               b_p0_ff;
   side_info_type            b_info_ff;

   logic [CoordW+1:0]        sum_in [3];
   result_type               res_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         scale_in[k] = $signed(diff_ff[k]) * $signed({1'b0, a_quo_ff});
         sum_in[k]   = {{2{b_p0_ff[k][CoordW-1]}}, b_p0_ff[k]} +
                       scale_ff[k][ScaleW-1:QW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            diff_ff[k]  <= {in_data.seg.p1[k][CoordW-1], in_data.seg.p1[k]} -
                           {in_data.seg.p0[k][CoordW-1], in_data.seg.p0[k]};
            scale_ff[k] <= scale_in[k];
            res_ff.split[k] <= b_info_ff.crosses ? sum_in[k][CoordW-1:0] : '0;
         end
         a_p0_ff   <= in_data.seg.p0;
         a_info_ff <= in_data.seg.info;
         a_quo_ff  <= in_data.quo;
         b_p0_ff   <= a_p0_ff;
         b_info_ff <= a_info_ff;
         res_ff.info <= b_info_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = res_ff;

endmodule

`default_nettype wire

// ----- rtl/segment_plane_split_point.sv -----
// top level: plane registers, evaluation, divider chain, interpolation, output skid
// uses spsp_pkg, spsp_plane_eval, spsp_div_stage, spsp_interp
//
//   group   direction  payload (lowest bit up)
//   req_    in         tdata: start_x, start_y, start_z, end_x, end_y, end_z
//   rsp_    out        tdata: start_side, end_side, split_x, split_y, split_z, pad
//                      tuser: crosses
//   csr_    in         we, index, wdata (plane_a, plane_b, plane_c, plane_offset)
//
// one item per cycle while the skid register is empty; the divider is a chain of
// 16 / DivSteps restoring divider stages
// synchronous reset clears all valid bits and the plane registers to zero
// a stalled output holds its item while one more lands in the skid register;
// the whole pipeline then freezes and req_tready falls until the skid drains
`default_nettype none

module segment_plane_split_point import spsp_pkg::*; #(
   parameter int unsigned DivSteps = StepsPerStage
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,   // start_x .. end_z, 32 bits each
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata,   // start_side, end_side, split_x/y/z
   output logic                     rsp_tuser,   // crosses
   input  wire logic                csr_we,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   localparam int DivStageCnt = QW / DivSteps;

   logic [NumRegs-1:0][CoordW-1:0] plane_ff;
   logic                           en;
   coord3_type                     in_p0, in_p1;

   logic                           div_valid [DivStageCnt+1];
   div_type                        div_data  [DivStageCnt+1];

   logic                           res_valid;
   result_type                     res_data;

   logic                           rsp_valid_ff, skid_valid_ff;
   result_type                     rsp_data_ff, skid_data_ff;
   logic                           rsp_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            RegPlaneA:      plane_ff[RegPlaneA]      <= csr_wdata;
            RegPlaneB:      plane_ff[RegPlaneB]      <= csr_wdata;
            RegPlaneC:      plane_ff[RegPlaneC]      <= csr_wdata;
            RegPlaneOffset: plane_ff[RegPlaneOffset] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_p0[k] = req_tdata[k*CoordW +: CoordW];
         in_p1[k] = req_tdata[(k+3)*CoordW +: CoordW];
      end
   end

   spsp_plane_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_p0     (in_p0),
      .in_p1     (in_p1),
      .plane     (plane_ff),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   for (genvar g = 0; g < DivStageCnt; g++) begin : g_div
      spsp_div_stage #(.Steps(DivSteps)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[g]),
         .in_data   (div_data[g]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   spsp_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid[DivStageCnt]),
      .in_data   (div_data[DivStageCnt]),
      .out_valid (res_valid),
      .out_data  (res_data)
   );

   assign rsp_take = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_ff <= res_valid;
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_data_ff <= res_data;
      end else begin
         skid_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.info.crosses;
   assign rsp_tdata  = {{RspPadW{1'b0}}, rsp_data_ff.split[2], rsp_data_ff.split[1],
                        rsp_data_ff.split[0], rsp_data_ff.info.end_side,
                        rsp_data_ff.info.start_side};

   // skid only fills behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid item without a held result");

   // a stalled skid keeps its item
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff)
      else $error("skid item dropped under stall");

   // a crossing needs one endpoint strictly below and the other strictly above
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.info.crosses |->
         (rsp_data_ff.info.start_side == SideBelow &&
          rsp_data_ff.info.end_side == SideAbove) ||
         (rsp_data_ff.info.start_side == SideAbove &&
          rsp_data_ff.info.end_side == SideBelow))
      else $error("crossing flagged with inconsistent sides");

   // no crossing gives a zero split point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.info.crosses |-> rsp_data_ff.split == '0)
      else $error("split point set without a crossing");

endmodule

`default_nettype wire
